[sv/frbt_pkg.sv]
// Package for the free block remap translator.
// Holds shared constants, opcodes, status codes, the command record and the sequencer states.
// No dependencies.
package frbt_pkg;

	localparam int MAX_BLOCKS   = 65536;
	localparam int MAX_SEGMENTS = 64;
	localparam int BLK_W        = $clog2(MAX_BLOCKS);
	localparam int CNT_W        = 17;
	localparam int POS_W        = $clog2(MAX_BLOCKS / 8) + 1;
	localparam int SEG_W        = $clog2(MAX_SEGMENTS + 1);
	localparam int BYTE_BITS    = 8;
	localparam int BIT_W        = $clog2(BYTE_BITS);

	localparam logic [4:0] SHIFT_MIN   = 5'd9;
	localparam logic [4:0] SHIFT_MAX   = 5'd16;
	localparam logic [4:0] SHIFT_RESET = 5'd12;

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BEYOND   = 2'd1;
	localparam logic [1:0] STAT_TOO_MANY = 2'd2;

	localparam logic REG_BLOCK_SHIFT = 1'b0;
	localparam logic REG_MAP_BLOCKS  = 1'b1;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_LOAD,
		OP_READ,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  bitmap_byte;
		logic [31:0] offset;
		logic [31:0] count;
		logic [32:0] req_end;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CHECK,
		ST_DECIDE,
		ST_ADDR,
		ST_SEG,
		ST_SINGLE
	} state_t;

	typedef struct packed {
		logic pop;
		logic ram_we;
		logic ram_re;
		logic emit_seg;
		logic emit_single;
	} back_ctl_t;

endpackage

[sv/frbt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module frbt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/frbt_front.sv]
// Front end: accepts input transactions, classifies the mode and precomputes the request end.
// Depends on frbt_pkg.
module frbt_front import frbt_pkg::*; (
	input  logic        item_valid,
	input  logic [1:0]  mode,
	input  logic [7:0]  bitmap_byte,
	input  logic [31:0] request_offset,
	input  logic [31:0] request_count,
	input  logic        queue_full,
	output logic        push,
	output cmd_t        cmd
);

	op_t op;

	always_comb begin
		case (mode)
			MODE_CLEAR: op = OP_CLEAR;
			MODE_LOAD:  op = OP_LOAD;
			MODE_READ:  op = OP_READ;
			default:    op = OP_NONE;
		endcase
	end

	assign push            = item_valid && !queue_full;
	assign cmd.op          = op;
	assign cmd.bitmap_byte = bitmap_byte;
	assign cmd.offset      = request_offset;
	assign cmd.count       = request_count;
	assign cmd.req_end     = {1'b0, request_offset} + {1'b0, request_count};

endmodule

[sv/frbt_queue.sv]
// Two-entry command queue between the front end and the sequencer.
// Depends on frbt_pkg.
module frbt_queue import frbt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full       = (fill_q == 2'd2);
	assign head_valid = (fill_q != 2'd0);
	assign head_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[sv/frbt_back.sv]
// Sequencer: clears and loads the free block table, checks reads and emits device segments.
// Depends on frbt_pkg and frbt_ram.
module frbt_back import frbt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	input  logic [4:0]       block_shift,
	input  logic [CNT_W-1:0] map_blocks,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [31:0]      segment_offset,
	output logic [16:0]      segment_length,
	output logic [1:0]       status,
	output logic [16:0]      free_entries,
	output logic             last
);

	state_t           state_q;
	state_t           state_d;
	back_ctl_t        ctl;
	logic [CNT_W-1:0] free_count_q;
	logic [POS_W-1:0] load_pos_q;
	logic [7:0]       byte_q;
	logic [BIT_W-1:0] bit_q;
	logic [31:0]      off_q;
	logic [31:0]      cnt_q;
	logic [32:0]      end_q;
	logic [33:0]      size_q;
	logic [32:0]      sum_q;
	logic [BLK_W-1:0] idx_q;
	logic [15:0]      inb_q;
	logic [SEG_W-1:0] seg_left_q;
	logic [1:0]       status_q;
	logic             out_valid_q;

	logic [4:0]       sh;
	logic [16:0]      bs;
	logic [15:0]      inb_w;
	logic [CNT_W-1:0] base_w;
	logic [CNT_W-1:0] blk_w;
	logic             base_past;
	logic             blk_past;
	logic             table_full;
	logic             bit_free;
	logic [32:0]      nseg_w;
	logic             beyond;
	logic             too_many;
	logic [16:0]      room_w;
	logic [16:0]      len_w;
	logic [31:0]      dev_w;
	logic [BLK_W-1:0] ram_rdata;
	logic             out_free;
	logic             seg_last;

	always_comb begin
		if (block_shift < SHIFT_MIN) begin
			sh = SHIFT_MIN;
		end else if (block_shift > SHIFT_MAX) begin
			sh = SHIFT_MAX;
		end else begin
			sh = block_shift;
		end
	end

	assign bs         = 17'd1 << sh;
	assign inb_w      = off_q[15:0] & 16'(bs - 17'd1);
	assign base_w     = CNT_W'({load_pos_q, 3'b000});
	assign blk_w      = base_w + CNT_W'(bit_q);
	assign base_past  = (base_w >= map_blocks) || (base_w >= CNT_W'(MAX_BLOCKS));
	assign blk_past   = (blk_w >= map_blocks);
	assign table_full = (free_count_q >= CNT_W'(MAX_BLOCKS));
	assign bit_free   = !byte_q[3'(BYTE_BITS - 1) - bit_q];
	assign nseg_w     = sum_q >> sh;
	assign beyond     = ({2'b00, off_q} >= size_q) || ({1'b0, end_q} > size_q);
	assign too_many   = (nseg_w > 33'(MAX_SEGMENTS));
	assign room_w     = bs - {1'b0, inb_q};
	assign len_w      = ({15'd0, room_w} > cnt_q) ? cnt_q[16:0] : room_w;
	assign dev_w      = (32'(ram_rdata) << sh) + 32'(inb_q);
	assign out_free   = !out_valid_q || !result_stall;
	assign seg_last   = (seg_left_q == SEG_W'(1));

	frbt_ram #(
		.WIDTH(BLK_W),
		.DEPTH(MAX_BLOCKS)
	) u_map (
		.clk  (clk),
		.we   (ctl.ram_we),
		.waddr(free_count_q[BLK_W-1:0]),
		.wdata(blk_w[BLK_W-1:0]),
		.re   (ctl.ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						OP_READ: state_d = ST_CHECK;
						OP_LOAD: state_d = base_past ? ST_SINGLE : ST_LOAD;
						default: state_d = ST_SINGLE;
					endcase
				end
			end
			ST_LOAD: begin
				if (blk_past || bit_q == BIT_W'(BYTE_BITS - 1)) begin
					state_d = ST_SINGLE;
				end
			end
			ST_CHECK: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (beyond || cnt_q == 32'd0 || too_many) begin
					state_d = ST_SINGLE;
				end else begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR: state_d = ST_SEG;
			ST_SEG: begin
				if (out_free) begin
					state_d = seg_last ? ST_IDLE : ST_ADDR;
				end
			end
			ST_SINGLE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE:   ctl.pop = cmd_valid;
			ST_LOAD:   ctl.ram_we = !blk_past && bit_free && !table_full;
			ST_ADDR:   ctl.ram_re = 1'b1;
			ST_SEG:    ctl.emit_seg = out_free;
			ST_SINGLE: ctl.emit_single = out_free;
			default:   ctl = '0;
		endcase
	end

	assign cmd_pop = ctl.pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			free_count_q <= '0;
			load_pos_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.pop && cmd.op == OP_CLEAR) begin
				free_count_q <= '0;
				load_pos_q   <= '0;
			end
			if (ctl.ram_we) begin
				free_count_q <= free_count_q + CNT_W'(1);
			end
			if (state_q == ST_LOAD && (blk_past || bit_q == BIT_W'(BYTE_BITS - 1))) begin
				load_pos_q <= load_pos_q + POS_W'(1);
			end
			if (ctl.emit_seg || ctl.emit_single) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				status_q <= STAT_OK;
				byte_q   <= cmd.bitmap_byte;
				bit_q    <= '0;
				off_q    <= cmd.offset;
				cnt_q    <= cmd.count;
				end_q    <= cmd.req_end;
			end
			ST_LOAD: begin
				bit_q <= bit_q + BIT_W'(1);
			end
			ST_CHECK: begin
				size_q <= 34'(free_count_q) << sh;
				inb_q  <= inb_w;
				idx_q  <= BLK_W'(off_q >> sh);
				sum_q  <= 33'(inb_w) + 33'(cnt_q) + 33'(bs) - 33'd1;
			end
			ST_DECIDE: begin
				seg_left_q <= nseg_w[SEG_W-1:0];
				if (beyond) begin
					status_q <= STAT_BEYOND;
				end else if (cnt_q == 32'd0) begin
					status_q <= STAT_OK;
				end else if (too_many) begin
					status_q <= STAT_TOO_MANY;
				end
			end
			ST_SEG: begin
				if (out_free) begin
					cnt_q      <= cnt_q - 32'(len_w);
					inb_q      <= '0;
					idx_q      <= idx_q + BLK_W'(1);
					seg_left_q <= seg_left_q - SEG_W'(1);
				end
			end
			default: begin
				status_q <= status_q;
			end
		endcase
		if (ctl.emit_seg) begin
			segment_offset <= dev_w;
			segment_length <= len_w;
			status         <= STAT_OK;
			free_entries   <= free_count_q;
			last           <= seg_last;
		end else if (ctl.emit_single) begin
			segment_offset <= '0;
			segment_length <= '0;
			status         <= status_q;
			free_entries   <= free_count_q;
			last           <= 1'b1;
		end
	end

	assign result_valid = out_valid_q;

endmodule

[sv/free_block_remap_translator_top.sv]
// Free block remap translator top level: configuration registers, front end, queue, sequencer.
// Depends on frbt_pkg, frbt_front, frbt_queue and frbt_back.
//
// Use: write block_shift (index 0) and map_blocks (index 1) through the cfg channel while
// idle; cfg_ready is always high. Send items on the item channel (item_valid/item_stall):
// mode 0 clears the free block table, mode 1 loads one allocation bitmap byte, mode 2 is a
// read request, mode 3 does nothing. Results leave on the result channel
// (result_valid/result_stall), one per clear, load or idle item and one per segment of a read
// (or one status result for a read that emits none), with last marking the final result of
// an item. Clear and mode 3 go straight to their result. A load steps through its bitmap bits
// one per cycle in the sequencer, set by the single table write port. A read passes through
// the check and decide states, then an address state and a segment state per segment, set by
// the table read port and its registered data. A two-entry queue lets items enter while the
// sequencer works. Reset clears the table count, load position and queue and sets block_shift
// to 12 and map_blocks to 0; the table contents are not cleared. While result_stall is high
// and a result is valid, the result register holds and the sequencer waits before its next
// result; item_stall rises once the queue is full.
module free_block_remap_translator_top import frbt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  bitmap_byte,
	input  logic [31:0] request_offset,
	input  logic [31:0] request_count,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] segment_offset,
	output logic [16:0] segment_length,
	output logic [1:0]  status,
	output logic [16:0] free_entries,
	output logic        last
);

	logic [4:0]       block_shift_q;
	logic [CNT_W-1:0] map_blocks_q;
	logic             push;
	cmd_t             push_cmd;
	logic             queue_full;
	logic             head_valid;
	cmd_t             head_cmd;
	logic             pop;

	assign cfg_ready  = 1'b1;
	assign item_stall = queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_shift_q <= SHIFT_RESET;
			map_blocks_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BLOCK_SHIFT: block_shift_q <= cfg_data[4:0];
				REG_MAP_BLOCKS:  map_blocks_q <= cfg_data;
				default:         block_shift_q <= block_shift_q;
			endcase
		end
	end

	frbt_front u_front (
		.item_valid    (item_valid),
		.mode          (mode),
		.bitmap_byte   (bitmap_byte),
		.request_offset(request_offset),
		.request_count (request_count),
		.queue_full    (queue_full),
		.push          (push),
		.cmd           (push_cmd)
	);

	frbt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (queue_full),
		.head_valid(head_valid),
		.head_cmd  (head_cmd)
	);

	frbt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (head_valid),
		.cmd           (head_cmd),
		.cmd_pop       (pop),
		.block_shift   (block_shift_q),
		.map_blocks    (map_blocks_q),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.segment_offset(segment_offset),
		.segment_length(segment_length),
		.status        (status),
		.free_entries  (free_entries),
		.last          (last)
	);

endmodule

[tb/tb.sv]
// Testbench for free_block_remap_translator_top: clear, bitmap load and read transactions
// are predicted by a scoreboard class and checked against every result transaction.
// Depends on frbt_pkg and the RTL of the block.
module tb import frbt_pkg::*; ();

	typedef struct packed {
		logic [31:0] dev_off;
		logic [16:0] seg_len;
		logic [1:0]  stat;
		logic [16:0] free_cnt;
		logic        tail;
	} segment_t;

	class free_map_scoreboard;
		logic [15:0] free_table [MAX_BLOCKS];
		logic [16:0] free_cnt;
		logic [13:0] load_pos;
		logic [4:0]  shift_reg;
		logic [16:0] total_reg;
		segment_t    pending_segments [$];
		int          errors;

		function new();
			free_cnt  = '0;
			load_pos  = '0;
			shift_reg = SHIFT_RESET;
			total_reg = '0;
			errors    = 0;
		endfunction

		function int pending();
			return pending_segments.size();
		endfunction

		function int unsigned used_shift();
			if (shift_reg < SHIFT_MIN)
				return 32'(SHIFT_MIN);
			if (shift_reg > SHIFT_MAX)
				return 32'(SHIFT_MAX);
			return 32'(shift_reg);
		endfunction

		function void set_reg(logic idx, logic [16:0] val);
			if (idx == REG_BLOCK_SHIFT)
				shift_reg = val[4:0];
			else
				total_reg = val;
		endfunction

		function void push_segment(longint unsigned off, longint unsigned len, logic [1:0] st,
				logic tail);
			segment_t s;
			s.dev_off  = off[31:0];
			s.seg_len  = len[16:0];
			s.stat     = st;
			s.free_cnt = free_cnt;
			s.tail     = tail;
			pending_segments.push_back(s);
		endfunction

		function void append_bits(logic [7:0] bits);
			longint unsigned base, blk;
			base = 64'(load_pos);
			base = base * 8;
			if (base >= total_reg || base >= MAX_BLOCKS)
				return;
			for (int i = 0; i < 8; i++) begin
				blk = base + 64'(i);
				if (blk < total_reg && blk < MAX_BLOCKS && !bits[7 - i] &&
						free_cnt < MAX_BLOCKS) begin
					free_table[free_cnt[15:0]] = blk[15:0];
					free_cnt++;
				end
			end
			load_pos++;
		endfunction

		function void plan_read(logic [31:0] req_off, logic [31:0] req_cnt);
			int unsigned sh;
			longint unsigned bsz, img, off, cnt, blk, inb, nseg, len, dev;
			sh  = used_shift();
			bsz = 64'd1 << sh;
			img = 64'(free_cnt);
			img = img << sh;
			off = 64'(req_off);
			cnt = 64'(req_cnt);
			if (off >= img || off + cnt > img) begin
				push_segment(64'd0, 64'd0, STAT_BEYOND, 1'b1);
				return;
			end
			if (cnt == 0) begin
				push_segment(64'd0, 64'd0, STAT_OK, 1'b1);
				return;
			end
			blk  = off >> sh;
			inb  = off & (bsz - 1);
			nseg = (inb + cnt + bsz - 1) >> sh;
			if (nseg > MAX_SEGMENTS) begin
				push_segment(64'd0, 64'd0, STAT_TOO_MANY, 1'b1);
				return;
			end
			for (longint unsigned k = 0; k < nseg; k++) begin
				len = bsz - inb;
				if (len > cnt)
					len = cnt;
				dev = 64'(free_table[blk + k]);
				dev = (dev << sh) + inb;
				push_segment(dev, len, STAT_OK, k + 1 == nseg);
				cnt -= len;
				inb = 0;
			end
		endfunction

		function void note_item(op_t op, logic [7:0] bits, logic [31:0] off, logic [31:0] cnt);
			case (op)
				OP_CLEAR: begin
					free_cnt = '0;
					load_pos = '0;
					push_segment(64'd0, 64'd0, STAT_OK, 1'b1);
				end
				OP_LOAD: begin
					append_bits(bits);
					push_segment(64'd0, 64'd0, STAT_OK, 1'b1);
				end
				OP_READ: plan_read(off, cnt);
				default: push_segment(64'd0, 64'd0, STAT_OK, 1'b1);
			endcase
		endfunction

		function void check_segment(segment_t got);
			segment_t want;
			if (pending_segments.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: off=%h len=%h st=%0d free=%0d last=%b",
						got.dev_off, got.seg_len, got.stat, got.free_cnt, got.tail);
				return;
			end
			want = pending_segments.pop_front();
			if (got.dev_off !== want.dev_off || got.seg_len !== want.seg_len ||
					got.stat !== want.stat || got.free_cnt !== want.free_cnt ||
					got.tail !== want.tail) begin
				errors++;
				if (errors <= 10)
					$display("result differs: expected off=%h len=%h st=%0d free=%0d last=%b, %s",
						want.dev_off, want.seg_len, want.stat, want.free_cnt, want.tail,
						$sformatf("got off=%h len=%h st=%0d free=%0d last=%b",
							got.dev_off, got.seg_len, got.stat, got.free_cnt, got.tail));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [16:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  mode = '0;
	logic [7:0]  bitmap_byte = '0;
	logic [31:0] request_offset = '0;
	logic [31:0] request_count = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [31:0] segment_offset;
	logic [16:0] segment_length;
	logic [1:0]  status;
	logic [16:0] free_entries;
	logic        last;

	free_map_scoreboard sb;
	int unsigned idle_rate = 0;
	int          items_sent = 0;
	int          stall_left = 0;

	free_block_remap_translator_top dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
			stall_left = $urandom_range(0, 10);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		segment_t got;
		if (arst_n && result_valid && !result_stall) begin
			got.dev_off  = segment_offset;
			got.seg_len  = segment_length;
			got.stat     = status;
			got.free_cnt = free_entries;
			got.tail     = last;
			sb.check_segment(got);
		end
	end

	task automatic send_item(op_t op, logic [7:0] bits, logic [31:0] off, logic [31:0] cnt);
		if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		item_valid     <= 1'b1;
		mode           <= op;
		bitmap_byte    <= bits;
		request_offset <= off;
		request_count  <= cnt;
		do @(posedge clk); while (item_stall);
		sb.note_item(op, bits, off, cnt);
		items_sent++;
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [16:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_read(logic [31:0] off, logic [31:0] cnt);
		send_item(OP_READ, 8'($urandom), off, cnt);
	endtask

	task automatic random_load();
		logic [7:0] bits;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			bits = 8'($urandom);
		else if (pick < 6)
			bits = 8'h00;
		else if (pick < 8)
			bits = 8'hFF;
		else
			bits = ~(8'h01 << $urandom_range(0, 7));
		send_item(OP_LOAD, bits, $urandom, $urandom);
	endtask

	task automatic random_read();
		longint unsigned bsz, img, off, cnt, span;
		int unsigned pick;
		bsz = 64'd1 << sb.used_shift();
		img = 64'(sb.free_cnt);
		img = img << sb.used_shift();
		pick = $urandom_range(0, 99);
		if (img == 0 || pick < 8) begin
			off = 64'($urandom);
			cnt = 64'($urandom);
		end else begin
			off = 64'($urandom);
			off = off % img;
			if ($urandom_range(0, 3) == 0)
				off = off & ~(bsz - 1);
			span = img - off;
			if (pick < 16)
				cnt = span + 64'($urandom_range(1, 3000));
			else if (pick < 24)
				cnt = 64 * bsz + 64'($urandom_range(1, 32'(2 * bsz)));
			else if (pick < 29)
				cnt = 0;
			else if (pick < 36)
				cnt = span;
			else begin
				cnt = (pick < 70) ? 64'($urandom_range(1, 32'(2 * bsz))) :
					64'($urandom_range(1, 32'(64 * bsz)));
				if (cnt > span)
					cnt = span;
			end
		end
		send_read(off[31:0], cnt[31:0]);
	endtask

	task automatic random_item();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 84)
			random_read();
		else if (pick < 90)
			send_item(OP_NONE, 8'($urandom), $urandom, $urandom);
		else if (pick < 95)
			random_load();
		else
			send_item(op_t'($urandom_range(0, 3)), 8'($urandom), $urandom, $urandom);
	endtask

	initial begin
		#30_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int unsigned total, nbytes;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_rate = 20;
		send_read(32'd0, 32'd0);
		send_item(OP_LOAD, 8'h00, 32'd0, 32'd0);
		send_item(OP_NONE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait_drained();
		write_reg(REG_MAP_BLOCKS, 17'd20);
		write_reg(REG_BLOCK_SHIFT, 17'd0);
		send_item(OP_CLEAR, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_LOAD, 8'h00, 32'd0, 32'd0);
		send_item(OP_LOAD, 8'hFF, 32'd0, 32'd0);
		send_item(OP_LOAD, 8'hA5, 32'd0, 32'd0);
		send_item(OP_LOAD, 8'h00, 32'd0, 32'd0);
		send_read(32'd0, 32'd1);
		send_read(32'd0, 32'd512);
		send_read(32'd100, 32'd2000);
		send_read(32'd5119, 32'd1);
		send_read(32'd5119, 32'd2);
		send_read(32'd5120, 32'd0);
		send_read(32'd10, 32'd0);
		send_read(32'd0, 32'd5120);
		send_read(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_NONE, 8'h00, 32'd0, 32'd0);

		while (items_sent < 220) begin
			wait_drained();
			case ($urandom_range(0, 2))
				0: idle_rate = 0;
				1: idle_rate = 10;
				default: idle_rate = 30;
			endcase
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_BLOCK_SHIFT, 17'($urandom_range(0, 31)));
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0: total = $urandom_range(0, 8);
					1, 2, 3, 4, 5, 6: total = $urandom_range(1, 300);
					default: total = $urandom_range(301, 600);
				endcase
				write_reg(REG_MAP_BLOCKS, 17'(total));
			end
			send_item(OP_CLEAR, 8'($urandom), $urandom, $urandom);
			nbytes = (sb.total_reg + 7) / 8 + $urandom_range(0, 2);
			for (int i = 0; i < nbytes; i++) begin
				if ($urandom_range(0, 9) == 0)
					random_read();
				random_load();
			end
			repeat ($urandom_range(4, 12)) random_item();
		end

		wait_drained();
		idle_rate = 10;
		write_reg(REG_BLOCK_SHIFT, 17'd31);
		write_reg(REG_MAP_BLOCKS, 17'd65536);
		send_item(OP_CLEAR, 8'($urandom), $urandom, $urandom);
		for (int i = 0; i < 24; i++)
			send_item(OP_LOAD, 8'h00, $urandom, $urandom);

		idle_rate = 0;
		send_read(32'hFFFF_FFFF, 32'd1);
		send_read(32'hFFFF_FFFF, 32'd0);
		send_read(32'd0, 32'h0040_0000);
		send_read(32'd0, 32'h0040_0001);
		send_read(32'hFFFF_0000, 32'h0001_0000);
		send_read(32'h8000_7FFF, 32'h0003_0002);
		send_read(32'd1, 32'hFFFF_FFFF);
		repeat (40) random_read();

		wait_drained();
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

[free_block_remap_translator_top.f]
sv/frbt_pkg.sv
sv/frbt_ram.sv
sv/frbt_front.sv
sv/frbt_queue.sv
sv/frbt_back.sv
sv/free_block_remap_translator_top.sv
tb/tb.sv
